FILE: hw/rtl/cpg_pkg.sv
// shared constants, types and functions of the phase oscillator step
`default_nettype none
package cpg_pkg;
    localparam int FRAC_BITS_DEF = 12;
    localparam int SINE_ITER_DEF = 14;
    localparam int TAB_LEN = 20;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic signed [31:0] CORDIC_X0 = 32'sd652032874;
    localparam logic [13:0] INV_TWO_PI_Q16 = 14'd10430;

    localparam logic [CFG_IDX_W-1:0] REG_AMP_TGT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_TGT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS1     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS2     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TSTEP     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 3'd7;

    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        case (i)
            5'd0:  atan_turn = 32'h20000000;
            5'd1:  atan_turn = 32'h12E4051E;
            5'd2:  atan_turn = 32'h09FB385B;
            5'd3:  atan_turn = 32'h051111D4;
            5'd4:  atan_turn = 32'h028B0D43;
            5'd5:  atan_turn = 32'h0145D7E1;
            5'd6:  atan_turn = 32'h00A2F61E;
            5'd7:  atan_turn = 32'h00517C55;
            5'd8:  atan_turn = 32'h0028BE53;
            5'd9:  atan_turn = 32'h00145F2F;
            5'd10: atan_turn = 32'h000A2F98;
            5'd11: atan_turn = 32'h000517CC;
            5'd12: atan_turn = 32'h00028BE6;
            5'd13: atan_turn = 32'h000145F3;
            5'd14: atan_turn = 32'h0000A2F9;
            5'd15: atan_turn = 32'h0000517C;
            5'd16: atan_turn = 32'h000028BE;
            5'd17: atan_turn = 32'h0000145F;
            5'd18: atan_turn = 32'h00000A2F;
            5'd19: atan_turn = 32'h00000517;
            default: atan_turn = 32'h0;
        endcase
    endfunction

    typedef struct packed {
        logic start;
        logic busy;
    } t_lane_ctl;
endpackage
`default_nettype wire

FILE: hw/rtl/cpg_coupling_lane.sv
// one coupling lane: iterative cordic sine, then weight and 1/(2 pi) scaling
`default_nettype none
module cpg_coupling_lane #(
    parameter int FRAC_BITS = cpg_pkg::FRAC_BITS_DEF,
    parameter int SINE_ITER = cpg_pkg::SINE_ITER_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic               i_present,
    input  wire logic [15:0]        i_angle,
    input  wire logic signed [15:0] i_weight,
    output logic                    o_done,
    output logic signed [31:0]      o_term
);
    import cpg_pkg::*;

    localparam int NIT = (SINE_ITER < TAB_LEN) ? SINE_ITER : TAB_LEN;
    localparam int SSH = 30 - FRAC_BITS;
    localparam int PSH = FRAC_BITS + 16;

    typedef enum logic [2:0] {S_IDLE, S_ROT, S_SINE, S_MUL1, S_MUL2, S_DONE} t_state;

    t_state                 r_state;
    logic [4:0]             r_it;
    logic signed [33:0]     r_x, r_y, r_z;
    logic                   r_neg, r_present;
    logic signed [22:0]     r_s;
    logic signed [38:0]     r_p1;
    logic signed [53:0]     r_p2;
    logic signed [31:0]     r_term;

    logic [31:0]            a_full, a_fold;
    logic                   fold;
    logic signed [33:0]     xs, ys, atn;
    logic signed [33:0]     yr;
    logic signed [22:0]     s_raw, s_one;
    logic signed [53:0]     p2r;

    always_comb begin
        a_full = {i_angle, 16'h0};
        fold   = (a_full >= 32'h40000000) && (a_full < 32'hC0000000);
        a_fold = fold ? (a_full - 32'h80000000) : a_full;
        xs  = r_x >>> r_it;
        ys  = r_y >>> r_it;
        atn = $signed({2'b00, atan_turn(r_it)});
        yr  = r_y + (34'sd1 <<< (SSH - 1));
        s_raw = 23'(yr >>> SSH);
        s_one = 23'sd1 <<< FRAC_BITS;
        p2r = r_p2 + (54'sd1 <<< (PSH - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_start) begin
                    r_x <= 34'(CORDIC_X0);
                    r_y <= '0;
                    r_z <= 34'($signed(a_fold));
                    r_neg <= fold;
                    r_present <= i_present;
                    r_it <= '0;
                    r_state <= S_ROT;
                end
                S_ROT: begin
                    if (!r_z[33]) begin
                        r_x <= r_x - ys; r_y <= r_y + xs; r_z <= r_z - atn;
                    end else begin
                        r_x <= r_x + ys; r_y <= r_y - xs; r_z <= r_z + atn;
                    end
                    r_it <= r_it + 5'd1;
                    if (r_it == 5'(NIT - 1)) r_state <= S_SINE;
                end
                S_SINE: begin
                    if (s_raw > s_one) r_s <= r_neg ? -s_one : s_one;
                    else if (s_raw < -s_one) r_s <= r_neg ? s_one : -s_one;
                    else r_s <= r_neg ? -s_raw : s_raw;
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    r_p1 <= 39'(i_weight) * 39'(r_s);
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_p2 <= 54'(r_p1) * 54'($signed({1'b0, INV_TWO_PI_Q16}));
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_term <= r_present ? 32'(p2r >>> PSH) : '0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done = (r_state == S_IDLE);
    assign o_term = r_term;
endmodule
`default_nettype wire

FILE: hw/rtl/cpg_pull.sv
// second-order pull of one value and its rate toward a target
`default_nettype none
module cpg_pull #(
    parameter logic signed [15:0] RESET_VAL = '0
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [15:0] i_target,
    input  wire logic [7:0]         i_gain,
    input  wire logic [15:0]        i_dt,
    output logic                    o_done,
    output logic signed [15:0]      o_val,
    output logic                    o_sat
);
    import cpg_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_M1, S_M2, S_M3, S_FIN} t_state;

    t_state             r_state;
    logic signed [15:0] r_val;
    logic signed [31:0] r_rate;
    logic signed [48:0] r_rdt;
    logic signed [35:0] r_inner;
    logic signed [44:0] r_ginner;
    logic signed [61:0] r_prod;
    logic               r_sat;

    logic signed [48:0] rdt_r;
    logic signed [61:0] prod_r;
    logic signed [33:0] nv;
    logic signed [45:0] nr;
    logic signed [16:0] diff;
    logic               sat_v, sat_r;

    always_comb begin
        diff   = 17'(i_target) - 17'(r_val);
        rdt_r  = r_rdt + 49'sd32768;
        prod_r = r_prod + (62'sd1 <<< 17);
        nv     = 34'(r_val) + 34'(rdt_r >>> 16);
        nr     = 46'(r_rate) + 46'(prod_r >>> 18);
        sat_v  = (nv > 34'sd32767) || (nv < -34'sd32768);
        sat_r  = (nr > 46'sh7FFFFFFF) || (nr < -46'sh80000000);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_val   <= RESET_VAL;
            r_rate  <= '0;
            r_sat   <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_start) begin
                    r_rdt   <= 49'(r_rate) * 49'($signed({1'b0, i_dt}));
                    r_inner <= 36'($signed({1'b0, i_gain})) * 36'(diff) - (36'(r_rate) <<< 2);
                    r_state <= S_M1;
                end
                S_M1: begin
                    r_ginner <= 45'($signed({1'b0, i_gain})) * 45'(r_inner);
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_prod <= 62'(r_ginner) * 62'($signed({1'b0, i_dt}));
                    r_state <= S_M3;
                end
                S_M3: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (nv > 34'sd32767) begin
                        r_val <= 16'sh7FFF;
                    end else if (nv < -34'sd32768) begin
                        r_val <= -16'sh8000;
                    end else begin
                        r_val <= 16'(nv);
                    end
                    if (nr > 46'sh7FFFFFFF) begin
                        r_rate <= 32'sh7FFFFFFF;
                    end else if (nr < -46'sh80000000) begin
                        r_rate <= 32'sh80000000;
                    end else begin
                        r_rate <= 32'(nr);
                    end
                    r_sat   <= sat_v || sat_r;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done = (r_state == S_IDLE);
    assign o_val  = r_val;
    assign o_sat  = r_sat;
endmodule
`default_nettype wire

FILE: hw/rtl/cpg_phase_oscillator_step.sv
// top level: two coupling lanes, two pull units and the phase merge stage
// An item runs through the launch, wait, sum, multiply and output states, and
// the next input transfer is taken only once its result is registered. In the
// wait state the two coupling lanes run their cordic rotations side by
// side, one stage a cycle, and the amplitude and offset pulls run meanwhile; a
// merge stage then sums the coupling terms, scales by the time step and wraps
// the phase. The result sits in an output register; the next item is taken
// while it waits, and the merge stage holds its last step until the register
// is free. Configuration writes take effect at once.
`default_nettype none
module cpg_phase_oscillator_step #(
    parameter int FRAC_BITS = cpg_pkg::FRAC_BITS_DEF,
    parameter int SINE_ITERATIONS = cpg_pkg::SINE_ITER_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [cpg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [cpg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [15:0]                    i_neighbor1_phase,
    input  wire logic                           i_neighbor1_present,
    input  wire logic [15:0]                    i_neighbor2_phase,
    input  wire logic                           i_neighbor2_present,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic [15:0]                         o_phase_out,
    output logic signed [15:0]                  o_amplitude_out,
    output logic signed [15:0]                  o_offset_out,
    output logic                                o_saturated
);
    import cpg_pkg::*;

    localparam logic [63:0] OFF_CALC = ((64'd2617994 << FRAC_BITS) + 64'd500000) / 64'd1000000;
    localparam logic signed [15:0] OFF_RST = (OFF_CALC > 64'd32767) ? 16'sh7FFF : 16'(OFF_CALC);

    typedef enum logic [2:0] {S_IDLE, S_LAUNCH, S_WAIT, S_SUM, S_MUL, S_OUT} t_state;

    t_state             r_state;
    logic [15:0]        r_amp_tgt, r_off_tgt, r_bias1, r_bias2, r_dt, r_weight;
    logic [14:0]        r_freq;
    logic [7:0]         r_gain;
    logic [15:0]        r_own, r_nb1, r_nb2;
    logic               r_pr1, r_pr2;
    logic signed [33:0] r_rate;
    logic signed [50:0] r_prod;
    logic               r_valid;
    logic [15:0]        r_phase_out;
    logic signed [15:0] r_amp_out, r_off_out;
    logic               r_sat_out;

    t_lane_ctl          lane_ctl;
    logic               l1_done, l2_done, pa_done, po_done;
    logic signed [31:0] l1_term, l2_term;
    logic signed [15:0] amp_val, off_val;
    logic               amp_sat, off_sat;
    logic [15:0]        ang1, ang2;
    logic signed [50:0] prod_r;

    assign ang1 = r_nb1 - r_own - r_bias1;
    assign ang2 = r_nb2 - r_own - r_bias2;
    assign lane_ctl.start = (r_state == S_LAUNCH);
    assign lane_ctl.busy  = !(l1_done && l2_done && pa_done && po_done);
    assign prod_r = r_prod + (51'sd1 <<< (FRAC_BITS - 1));

    cpg_coupling_lane #(.FRAC_BITS(FRAC_BITS), .SINE_ITER(SINE_ITERATIONS)) u_lane1 (
        .i_clk, .i_rst_n, .i_start(lane_ctl.start), .i_present(r_pr1), .i_angle(ang1),
        .i_weight(r_weight), .o_done(l1_done), .o_term(l1_term));
    cpg_coupling_lane #(.FRAC_BITS(FRAC_BITS), .SINE_ITER(SINE_ITERATIONS)) u_lane2 (
        .i_clk, .i_rst_n, .i_start(lane_ctl.start), .i_present(r_pr2), .i_angle(ang2),
        .i_weight(r_weight), .o_done(l2_done), .o_term(l2_term));
    cpg_pull #(.RESET_VAL(16'sh0000)) u_amp (
        .i_clk, .i_rst_n, .i_start(lane_ctl.start), .i_target(r_amp_tgt), .i_gain(r_gain),
        .i_dt(r_dt), .o_done(pa_done), .o_val(amp_val), .o_sat(amp_sat));
    cpg_pull #(.RESET_VAL(OFF_RST)) u_off (
        .i_clk, .i_rst_n, .i_start(lane_ctl.start), .i_target(r_off_tgt), .i_gain(r_gain),
        .i_dt(r_dt), .o_done(po_done), .o_val(off_val), .o_sat(off_sat));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amp_tgt <= '0;
            r_off_tgt <= '0;
            r_bias1   <= 16'd10923;
            r_bias2   <= 16'd54613;
            r_dt      <= 16'd19661;
            r_weight  <= 16'd3277;
            r_freq    <= 15'd1229;
            r_gain    <= 8'd30;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_AMP_TGT: r_amp_tgt <= i_cfg_data;
                REG_OFF_TGT: r_off_tgt <= i_cfg_data;
                REG_BIAS1:   r_bias1   <= i_cfg_data;
                REG_BIAS2:   r_bias2   <= i_cfg_data;
                REG_TSTEP:   r_dt      <= i_cfg_data;
                REG_WEIGHT:  r_weight  <= i_cfg_data;
                REG_FREQ:    r_freq    <= i_cfg_data[14:0];
                REG_GAIN:    r_gain    <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_own   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (r_valid && i_ready && (r_state != S_OUT)) r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_valid) begin
                    r_nb1 <= i_neighbor1_phase; r_pr1 <= i_neighbor1_present;
                    r_nb2 <= i_neighbor2_phase; r_pr2 <= i_neighbor2_present;
                    r_state <= S_LAUNCH;
                end
                S_LAUNCH: r_state <= S_WAIT;
                S_WAIT: if (!lane_ctl.busy) r_state <= S_SUM;
                S_SUM: begin
                    r_rate <= 34'($signed({1'b0, r_freq})) + 34'(l1_term) + 34'(l2_term);
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod <= 51'(r_rate) * 51'($signed({1'b0, r_dt}));
                    r_state <= S_OUT;
                end
                S_OUT: if (!r_valid || i_ready) begin
                    r_own       <= r_own + 16'(prod_r >>> FRAC_BITS);
                    r_phase_out <= r_own + 16'(prod_r >>> FRAC_BITS);
                    r_amp_out   <= amp_val;
                    r_off_out   <= off_val;
                    r_sat_out   <= amp_sat || off_sat;
                    r_valid     <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = r_valid;
    assign o_phase_out     = r_phase_out;
    assign o_amplitude_out = r_amp_out;
    assign o_offset_out    = r_off_out;
    assign o_saturated     = r_sat_out;
endmodule
`default_nettype wire
